>>> design/cluster_bitmask_to_item_list_macros.svh
// Assertion helpers for the list compaction block.
`ifndef CLUSTER_BITMASK_TO_ITEM_LIST_MACROS_SVH
`define CLUSTER_BITMASK_TO_ITEM_LIST_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CBIL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define CBIL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/cbil_pkg.sv
package cbil_pkg;

  localparam int unsigned OP_W      = 2;
  localparam int unsigned BLK_W     = 3;
  localparam int unsigned MASK_W    = 32;
  localparam int unsigned BIT_W     = 5;
  localparam int unsigned ADDR_W    = 20;
  localparam int unsigned ENTRY_W   = 30;
  localparam int unsigned CIDX_W    = 12;
  localparam int unsigned IN_DATA_W = 40;
  localparam int unsigned OUT_DATA_W = 112;

  typedef enum logic [OP_W-1:0] {
    OP_LIGHT = 2'd0,
    OP_DECAL = 2'd1,
    OP_PROBE = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LOAD,
    ST_SEND
  } state_t;

endpackage

>>> design/cbil_ram.sv
module cbil_ram #(
  parameter int unsigned WIDTH = 30,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/cluster_bitmask_to_item_list.sv
// Sequence: accept, then a bit-serial scan of the mask up to the highest set bit (stop
// early once the kind's count is full); each entry is loaded, then sent; the block
// ends with a final scan check unless an entry carries last, and a record is sent after that check.
// A new block is taken only in IDLE, once the last one is through; every result is held
// until taken. The scan is a single bit-serial one over a buffer with one write port.
// Reset (rst, synchronous): counts, offset and cluster counter clear; buffer is not cleared.
`include "cluster_bitmask_to_item_list_macros.svh"

module cluster_bitmask_to_item_list #(
  parameter int unsigned CLUSTER_COUNT = 4096,
  parameter int unsigned MAX_ITEMS     = 256,
  parameter int unsigned INDEX_BITS    = 10
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [2:0] block_index, [34:3] mask, [39:35] zero
  input  logic [cbil_pkg::IN_DATA_W-1:0] s_axis_tdata,
  // [1:0] op
  input  logic [cbil_pkg::OP_W-1:0]      s_axis_tuser,
  input  logic                           s_axis_tlast,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [19:0] address, [49:20] entry_value, [61:50] cluster_index,
  // [81:62] cluster_offset, [111:82] cluster_counts
  output logic [cbil_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // [0] is_record
  output logic                           m_axis_tuser,
  output logic                           m_axis_tlast
);

  import cbil_pkg::*;

  localparam int unsigned CNT_W  = $clog2(MAX_ITEMS + 1);
  localparam int unsigned SLOT_W = $clog2(MAX_ITEMS);
  localparam logic [ENTRY_W-1:0] FIELD_M = ENTRY_W'((1 << INDEX_BITS) - 1);

  state_t state, state_next;

  op_t                     op_q;
  logic [BLK_W-1:0]        blk_q;
  logic                    eoc_q;
  logic [MASK_W-1:0]       rem;
  logic [BIT_W-1:0]        bit_pos;
  logic [CNT_W-1:0]        light_count, decal_count, probe_count;
  logic [ADDR_W-1:0]       running_offset;
  logic [CIDX_W-1:0]       cluster_counter;

  logic                    out_is_record;
  logic                    out_last;
  logic [ADDR_W-1:0]       out_address;
  logic [ENTRY_W-1:0]      out_entry;
  logic [CIDX_W-1:0]       out_cidx;
  logic [ADDR_W-1:0]       out_coff;
  logic [ENTRY_W-1:0]      out_counts;

  logic [MASK_W-1:0]       in_range;
  logic                    accept;
  logic                    load_entry;
  logic                    load_record;
  logic [CNT_W-1:0]        cur_count;
  logic                    full;
  logic [SLOT_W-1:0]       slot;
  logic [CNT_W-1:0]        used;
  logic [CNT_W-1:0]        max_count;
  logic [ENTRY_W-1:0]      rd_data;
  logic [ENTRY_W-1:0]      base_word;
  logic [ENTRY_W-1:0]      idx_f;
  logic [ENTRY_W-1:0]      new_word;
  logic                    entry_last;
  logic [ENTRY_W-1:0]      packed_counts;

  // Bits whose item index lies beyond the list are dropped at accept.
  always_comb begin
    for (int i = 0; i < MASK_W; i++) begin
      in_range[i] = (11'({s_axis_tdata[BLK_W-1:0], BIT_W'(i)}) < 11'(MAX_ITEMS));
    end
  end

  always_comb begin
    unique case (op_q)
      OP_LIGHT: cur_count = light_count;
      OP_DECAL: cur_count = decal_count;
      OP_PROBE: cur_count = probe_count;
      default:  cur_count = '0;
    endcase
  end

  assign full      = (cur_count >= CNT_W'(MAX_ITEMS));
  assign slot      = cur_count[SLOT_W-1:0];
  assign used      = (light_count > decal_count) ? light_count : decal_count;
  assign max_count = (probe_count > used) ? probe_count : used;
  assign idx_f     = ENTRY_W'({blk_q, bit_pos}) & FIELD_M;

  assign packed_counts = (ENTRY_W'(light_count) & FIELD_M)
                       | ((ENTRY_W'(decal_count) & FIELD_M) << INDEX_BITS)
                       | ((ENTRY_W'(probe_count) & FIELD_M) << (2 * INDEX_BITS));

  always_comb begin
    base_word = '0;
    new_word  = idx_f;
    unique case (op_q)
      OP_DECAL: begin
        if (cur_count < light_count) base_word = rd_data;
        new_word = (base_word & ~(FIELD_M << INDEX_BITS)) | (idx_f << INDEX_BITS);
      end
      OP_PROBE: begin
        if (cur_count < used) base_word = rd_data;
        new_word = (base_word & ~(FIELD_M << (2 * INDEX_BITS)))
                 | (idx_f << (2 * INDEX_BITS));
      end
      default: new_word = idx_f;
    endcase
  end

  assign entry_last = !eoc_q
                    && ((rem[MASK_W-1:1] == '0)
                        || ((CNT_W + 1)'(cur_count) + 1'b1 >= (CNT_W + 1)'(MAX_ITEMS)));

  // Buffer is read at the current slot every cycle; data is used in LOAD.
  cbil_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(MAX_ITEMS)
  ) u_buf (
    .clk  (clk),
    .we   (load_entry),
    .waddr(slot),
    .wdata(new_word),
    .raddr(slot),
    .rdata(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    accept      = 1'b0;
    load_entry  = 1'b0;
    load_record = 1'b0;
    unique case (state)
      ST_IDLE: begin
        accept = s_axis_tvalid;
        if (s_axis_tvalid) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (rem == '0 || full) begin
          if (eoc_q) begin
            load_record = 1'b1;
            state_next  = ST_SEND;
          end else begin
            state_next = ST_IDLE;
          end
        end else if (rem[0]) begin
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        load_entry = 1'b1;
        state_next = ST_SEND;
      end
      ST_SEND: begin
        if (m_axis_tready) begin
          state_next = (out_is_record || out_last) ? ST_IDLE : ST_SCAN;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      light_count     <= '0;
      decal_count     <= '0;
      probe_count     <= '0;
      running_offset  <= '0;
      cluster_counter <= '0;
    end else begin
      if (load_entry) begin
        unique case (op_q)
          OP_LIGHT: light_count <= light_count + 1'b1;
          OP_DECAL: decal_count <= decal_count + 1'b1;
          OP_PROBE: probe_count <= probe_count + 1'b1;
          default:  ;
        endcase
      end
      if (load_record) begin
        light_count <= '0;
        decal_count <= '0;
        probe_count <= '0;
        // Wrap both counters after the final cluster.
        if (cluster_counter == CIDX_W'(CLUSTER_COUNT - 1)) begin
          cluster_counter <= '0;
          running_offset  <= '0;
        end else begin
          cluster_counter <= cluster_counter + 1'b1;
          running_offset  <= running_offset + ADDR_W'(max_count);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q    <= op_t'(s_axis_tuser);
      blk_q   <= s_axis_tdata[BLK_W-1:0];
      eoc_q   <= s_axis_tlast;
      bit_pos <= '0;
      rem     <= (op_t'(s_axis_tuser) == OP_NONE) ? '0
                 : (s_axis_tdata[BLK_W +: MASK_W] & in_range);
    end else if ((state == ST_SCAN && !(rem == '0 || full) && !rem[0]) || load_entry) begin
      // Advance past the current bit.
      rem     <= rem >> 1;
      bit_pos <= bit_pos + 1'b1;
    end

    if (load_entry) begin
      out_is_record <= 1'b0;
      out_last      <= entry_last;
      out_address   <= running_offset + ADDR_W'(cur_count);
      out_entry     <= new_word;
      out_cidx      <= '0;
      out_coff      <= '0;
      out_counts    <= '0;
    end else if (load_record) begin
      out_is_record <= 1'b1;
      out_last      <= 1'b1;
      out_address   <= '0;
      out_entry     <= '0;
      out_cidx      <= cluster_counter;
      out_coff      <= running_offset;
      out_counts    <= packed_counts;
    end
  end

  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = (state == ST_SEND);
  assign m_axis_tdata  = {out_counts, out_coff, out_cidx, out_entry, out_address};
  assign m_axis_tuser  = out_is_record;
  assign m_axis_tlast  = out_last;

  `CBIL_ASSERT_NOW(a_no_accept_while_sending, s_axis_tready, !m_axis_tvalid,
    "input taken while a result is pending")
  `CBIL_ASSERT_NOW(a_count_bound, 1'b1,
    light_count <= CNT_W'(MAX_ITEMS) && decal_count <= CNT_W'(MAX_ITEMS)
    && probe_count <= CNT_W'(MAX_ITEMS), "kind count beyond list depth")
  `CBIL_ASSERT_NOW(a_record_clears_counts, m_axis_tvalid && out_is_record,
    light_count == '0 && decal_count == '0 && probe_count == '0 && out_last,
    "record pending with live counts or without last")
  `CBIL_ASSERT_NEXT(a_last_returns_idle, m_axis_tvalid && m_axis_tready && out_last,
    s_axis_tready, "final transaction did not free the input side")

endmodule

>>> tb/cluster_bitmask_to_item_list_tb.sv
module cluster_bitmask_to_item_list_tb;
  import cbil_pkg::*;

  localparam int unsigned CLUSTERS   = 4096;
  localparam int unsigned LIST_DEPTH = 256;
  localparam int unsigned INDEX_W    = 10;
  localparam int unsigned IDLE_PCT   = 29;

  typedef struct packed {
    logic               is_record;
    logic [ADDR_W-1:0]  address;
    logic [ENTRY_W-1:0] entry_value;
    logic [CIDX_W-1:0]  cluster_index;
    logic [ADDR_W-1:0]  cluster_offset;
    logic [ENTRY_W-1:0] cluster_counts;
    logic               last;
  } list_result_t;

  class list_scoreboard;
    logic [ENTRY_W-1:0] slot_words [LIST_DEPTH];
    logic [ADDR_W-1:0]  base_addr;
    logic [CIDX_W-1:0]  cluster_num;
    int unsigned        n_light, n_decal, n_probe;
    list_result_t       expected_q[$];
    list_result_t       held;
    bit                 has_held;
    int unsigned        errors, blocks_seen, writes_seen, records_seen, index_wraps;

    function new();
      base_addr    = '0;
      cluster_num  = '0;
      n_light      = 0;
      n_decal      = 0;
      n_probe      = 0;
      has_held     = 1'b0;
      errors       = 0;
      blocks_seen  = 0;
      writes_seen  = 0;
      records_seen = 0;
      index_wraps  = 0;
    endfunction

    // Hold back one result so the final one of a transaction can get its last flag.
    function void stage(list_result_t r);
      if (has_held) expected_q.push_back(held);
      held     = r;
      has_held = 1'b1;
    endfunction

    function void note_block(op_t kind, logic [BLK_W-1:0] blk, logic [MASK_W-1:0] bits,
                             logic closes);
      int unsigned        item_no, slot, used, widest;
      logic [ENTRY_W-1:0] word;
      list_result_t       r;
      blocks_seen++;
      for (int b = 0; b < MASK_W; b++) begin
        if (kind == OP_NONE || !bits[b]) continue;
        item_no = int'(blk) * MASK_W + b;
        if (item_no >= LIST_DEPTH) continue;
        if (kind == OP_LIGHT) begin
          if (n_light >= LIST_DEPTH) continue;
          slot = n_light;
          n_light++;
          word = '0;
          word[INDEX_W-1:0] = item_no[INDEX_W-1:0];
        end else if (kind == OP_DECAL) begin
          if (n_decal >= LIST_DEPTH) continue;
          slot = n_decal;
          n_decal++;
          word = (slot < n_light) ? slot_words[slot] : '0;
          word[2*INDEX_W-1:INDEX_W] = item_no[INDEX_W-1:0];
        end else begin
          used = (n_light > n_decal) ? n_light : n_decal;
          if (n_probe >= LIST_DEPTH) continue;
          slot = n_probe;
          n_probe++;
          word = (slot < used) ? slot_words[slot] : '0;
          word[3*INDEX_W-1:2*INDEX_W] = item_no[INDEX_W-1:0];
        end
        slot_words[slot] = word;
        r             = '0;
        r.address     = base_addr + ADDR_W'(slot);
        r.entry_value = word;
        stage(r);
        writes_seen++;
      end
      if (closes) begin
        widest = n_light;
        if (n_decal > widest) widest = n_decal;
        if (n_probe > widest) widest = n_probe;
        r                = '0;
        r.is_record      = 1'b1;
        r.cluster_index  = cluster_num;
        r.cluster_offset = base_addr;
        r.cluster_counts = {n_probe[INDEX_W-1:0], n_decal[INDEX_W-1:0], n_light[INDEX_W-1:0]};
        stage(r);
        records_seen++;
        if (int'(cluster_num) + 1 >= CLUSTERS) begin
          cluster_num = '0;
          base_addr   = '0;
          index_wraps++;
        end else begin
          cluster_num++;
          base_addr += ADDR_W'(widest);
        end
        n_light = 0;
        n_decal = 0;
        n_probe = 0;
      end
      if (has_held) begin
        held.last = 1'b1;
        expected_q.push_back(held);
        has_held = 1'b0;
      end
    endfunction

    function void match_field(string label, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, label, want, got);
      end
    endfunction

    function void check_result(list_result_t got);
      list_result_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected, expected none, actual %h", $time, got);
        return;
      end
      want = expected_q.pop_front();
      match_field("is_record", want.is_record, got.is_record);
      match_field("address", want.address, got.address);
      match_field("entry_value", want.entry_value, got.entry_value);
      match_field("cluster_index", want.cluster_index, got.cluster_index);
      match_field("cluster_offset", want.cluster_offset, got.cluster_offset);
      match_field("cluster_counts", want.cluster_counts, got.cluster_counts);
      match_field("last", want.last, got.last);
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [OP_W-1:0]       s_axis_tuser = '0;
  logic                  s_axis_tlast = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tuser;
  logic                  m_axis_tlast;

  list_scoreboard sb = new();
  bit             steady = 1'b0;
  int unsigned    sent_items = 0;

  cluster_bitmask_to_item_list #(
    .CLUSTER_COUNT(CLUSTERS),
    .MAX_ITEMS    (LIST_DEPTH),
    .INDEX_BITS   (INDEX_W)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    m_axis_tready <= steady || ($urandom_range(99, 0) >= IDLE_PCT);
  end

  // Note inputs before checking outputs so a same-edge result always finds its expectation.
  always @(posedge clk) begin
    list_result_t got;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready)
        sb.note_block(op_t'(s_axis_tuser), s_axis_tdata[BLK_W-1:0],
                      s_axis_tdata[BLK_W +: MASK_W], s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) begin
        got.is_record      = m_axis_tuser;
        got.address        = m_axis_tdata[19:0];
        got.entry_value    = m_axis_tdata[49:20];
        got.cluster_index  = m_axis_tdata[61:50];
        got.cluster_offset = m_axis_tdata[81:62];
        got.cluster_counts = m_axis_tdata[111:82];
        got.last           = m_axis_tlast;
        sb.check_result(got);
      end
    end
  end

  // Call at a rising edge; returns at the edge where the transaction is taken.
  task automatic push_block(op_t kind, logic [BLK_W-1:0] blk, logic [MASK_W-1:0] bits,
                            logic closes);
    if (!steady) begin
      while ($urandom_range(99, 0) < IDLE_PCT) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {{(IN_DATA_W - MASK_W - BLK_W){1'b0}}, bits, blk};
    s_axis_tlast  <= closes;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sent_items++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [MASK_W-1:0] rand_mask();
    logic [MASK_W-1:0] bits;
    bits = '0;
    case ($urandom_range(9, 0))
      0: bits = '0;
      1: bits = '1;
      2, 3, 4: begin
        repeat ($urandom_range(3, 1)) bits[$urandom_range(MASK_W - 1, 0)] = 1'b1;
      end
      default: bits = $urandom();
    endcase
    return bits;
  endfunction

  // Lights, then decals, then probes; a few kinds get scrambled and a few ends come early.
  task automatic run_cluster();
    int unsigned n_l, n_d, n_p, total;
    op_t         kind;
    n_l   = $urandom_range(3, 0);
    n_d   = $urandom_range(3, 0);
    n_p   = $urandom_range(3, 0);
    total = n_l + n_d + n_p;
    if (total == 0) begin
      push_block(OP_NONE, BLK_W'($urandom_range(7, 0)), $urandom(), 1'b1);
      return;
    end
    for (int i = 0; i < total; i++) begin
      kind = (i < n_l) ? OP_LIGHT : (i < n_l + n_d) ? OP_DECAL : OP_PROBE;
      if ($urandom_range(99, 0) < 10) kind = op_t'($urandom_range(3, 0));
      push_block(kind, BLK_W'($urandom_range(7, 0)), rand_mask(),
                 (i == total - 1) || ($urandom_range(99, 0) < 3));
    end
  endtask

  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    push_block(OP_LIGHT, 3'd0, 32'h0000_0001, 1'b0);
    push_block(OP_DECAL, 3'd0, 32'h8000_0001, 1'b0);  // second decal lands past the lights
    push_block(OP_PROBE, 3'd7, 32'h8000_0000, 1'b1);

    // Kinds out of order: decal-only slots, then a light that overwrites slot 0
    push_block(OP_PROBE, 3'd1, 32'h0000_0003, 1'b0);
    push_block(OP_DECAL, 3'd2, 32'h0000_0007, 1'b0);
    push_block(OP_LIGHT, 3'd3, 32'h0000_0001, 1'b0);
    push_block(OP_PROBE, 3'd4, 32'h0000_0010, 1'b1);

    push_block(OP_NONE, 3'd5, 32'hFFFF_FFFF, 1'b0);   // unused kind writes nothing
    push_block(OP_LIGHT, 3'd6, 32'h0000_0000, 1'b0);  // empty mask, no result at all
    push_block(OP_NONE, 3'd0, 32'h0000_0000, 1'b1);   // record with zero counts

    // Fill the light list, then overflow it
    for (int b = 0; b < 8; b++) push_block(OP_LIGHT, BLK_W'(b), '1, 1'b0);
    push_block(OP_LIGHT, 3'd0, '1, 1'b0);
    push_block(OP_DECAL, 3'd7, '1, 1'b0);
    push_block(OP_PROBE, 3'd3, 32'h0000_FFFF, 1'b1);
    drain();

    while (sent_items < 170) begin
      steady <= (sent_items >= 80 && sent_items < 125);
      if (sent_items >= 140 && sent_items < 150) drain();
      if ($urandom_range(99, 0) < 85)
        run_cluster();
      else
        push_block(op_t'($urandom_range(3, 0)), BLK_W'($urandom_range(7, 0)), rand_mask(),
                   1'(($urandom_range(1, 0))));
    end
    steady <= 1'b0;

    drain();
    repeat (200) @(posedge clk);

    $display("Run covered %0d mask blocks, %0d list writes and %0d cluster records,",
             sb.blocks_seen, sb.writes_seen, sb.records_seen);
    $display("including %0d wrap(s) of the cluster index and offset.", sb.index_wraps);
    if (sb.errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
